### src/rpsc_pkg.sv
package rpsc_pkg;

   typedef enum logic [4:0] {
      MODE_TOP,
      MODE_ESC,
      MODE_ESC_C,
      MODE_X_HEX,
      MODE_U_FIRST,
      MODE_U_HEX,
      MODE_UB_HEX1,
      MODE_UB_SEL,
      MODE_UB_HEX2,
      MODE_UB_CLOSE,
      MODE_PAREN,
      MODE_PQ,
      MODE_PQL,
      MODE_LOOK_X,
      MODE_LOOK_CLOSE,
      MODE_NAME,
      MODE_NAME_ONE,
      MODE_NAME_CLOSE,
      MODE_SQUARE,
      MODE_BRACE
   } mode_type;

   typedef logic [3:0] err_type;

   localparam err_type ERR_NONE          = 4'd0;
   localparam err_type ERR_ESC_AT_END    = 4'd1;
   localparam err_type ERR_BAD_C         = 4'd2;
   localparam err_type ERR_BAD_U         = 4'd3;
   localparam err_type ERR_BAD_X         = 4'd4;
   localparam err_type ERR_BAD_LOOK      = 4'd5;
   localparam err_type ERR_BAD_NAME      = 4'd6;
   localparam err_type ERR_OPEN_PAREN    = 4'd7;
   localparam err_type ERR_OPEN_SQUARE   = 4'd8;
   localparam err_type ERR_EXTRA_COMMA   = 4'd9;
   localparam err_type ERR_BRACE_CHAR    = 4'd10;
   localparam err_type ERR_OPEN_BRACE    = 4'd11;

   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_Z = "Z";

   function automatic logic is_hex_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_plain_escape(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      case (c)
         "0", "b", "B", "d", "D", "f", "n", "r", "s", "S", "t", "v", "w", "W",
         "\\", "{", "}", "[", "]", "(", ")", "<", ">", "?", "=", ".", "*", "+",
         "^", "$", "!", "|", "-", ":", ",": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic err_type end_code(input mode_type m);
      err_type e;
      unique case (m)
         MODE_TOP: e = ERR_NONE;
         MODE_ESC: e = ERR_ESC_AT_END;
         MODE_ESC_C: e = ERR_BAD_C;
         MODE_X_HEX: e = ERR_BAD_X;
         MODE_U_FIRST, MODE_U_HEX, MODE_UB_HEX1, MODE_UB_SEL, MODE_UB_HEX2,
         MODE_UB_CLOSE: e = ERR_BAD_U;
         MODE_PAREN, MODE_PQ, MODE_PQL: e = ERR_OPEN_PAREN;
         MODE_LOOK_X, MODE_LOOK_CLOSE: e = ERR_BAD_LOOK;
         MODE_NAME, MODE_NAME_ONE, MODE_NAME_CLOSE: e = ERR_BAD_NAME;
         MODE_SQUARE: e = ERR_OPEN_SQUARE;
         MODE_BRACE: e = ERR_OPEN_BRACE;
         default: e = ERR_NONE;
      endcase
      return e;
   endfunction

endpackage

### src/regex_pattern_syntax_checker_top.sv
// Regex pattern syntax checker.
// The req channel carries one pattern character per item in req_ch, with req_last
// marking the final character of a pattern. Only the item that carries req_last
// produces a result on the rsp channel: rsp_pattern_ok, the first error code in
// rsp_error_code and the redundant escape flag in rsp_redundant_escape.
// Each character is one transition of a small parser state held in registers,
// so one item is accepted every cycle while req_ready is high. The result appears
// in the output register in the cycle after the last character is accepted.
// The parser state returns to its initial value after every result.
// While a result waits in the output register and rsp_ready is low, req_ready
// is low; when rsp_ready is high a new item is accepted in the same cycle as the
// waiting result is taken.
// Reset is synchronous and active high; it clears the parser state, the error
// and flag registers and the output valid.
module regex_pattern_syntax_checker_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_ch,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_pattern_ok,
   output rpsc_pkg::err_type      rsp_error_code,
   output logic                   rsp_redundant_escape
);
   import rpsc_pkg::*;

   mode_type   mode_ff, mode_in, mode_nx;
   logic [1:0] hex_left_ff, hex_left_in, hex_left_nx, hex_dec;
   logic       seen_comma_ff, seen_comma_in, seen_comma_nx;
   err_type    first_error_ff, first_error_in, first_error_nx;
   logic       redundant_ff, redundant_in, redundant_nx;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ok_ff, ok_in;
   err_type    code_ff, code_in;
   logic       red_out_ff, red_out_in;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign hex_dec   = hex_left_ff - 2'd1;

   always_comb begin
      mode_nx        = mode_ff;
      hex_left_nx    = hex_left_ff;
      seen_comma_nx  = seen_comma_ff;
      first_error_nx = first_error_ff;
      redundant_nx   = redundant_ff;

      if (first_error_ff == ERR_NONE) begin
         unique case (mode_ff)
            MODE_TOP, MODE_PAREN, MODE_PQ: begin
               if (mode_ff == MODE_PAREN && req_ch == "?") begin
                  mode_nx = MODE_PQ;
               end else if (mode_ff == MODE_PQ && (req_ch == "=" || req_ch == "!" ||
                                                   req_ch == ":")) begin
                  mode_nx = MODE_LOOK_X;
               end else if (mode_ff == MODE_PQ && req_ch == "<") begin
                  mode_nx = MODE_PQL;
               end else if (req_ch == "\\") begin
                  mode_nx = MODE_ESC;
               end else if (req_ch == "(") begin
                  mode_nx = MODE_PAREN;
               end else if (req_ch == "[") begin
                  mode_nx = MODE_SQUARE;
               end else if (req_ch == "{") begin
                  mode_nx       = MODE_BRACE;
                  seen_comma_nx = 1'b0;
               end else begin
                  mode_nx = MODE_TOP;
               end
            end
            MODE_ESC: begin
               if (req_ch == "c") begin
                  mode_nx = MODE_ESC_C;
               end else if (req_ch == "x") begin
                  mode_nx     = MODE_X_HEX;
                  hex_left_nx = 2'd2;
               end else if (req_ch == "u") begin
                  mode_nx = MODE_U_FIRST;
               end else begin
                  if (!is_plain_escape(req_ch)) begin
                     redundant_nx = 1'b1;
                  end
                  mode_nx = MODE_TOP;
               end
            end
            MODE_ESC_C: begin
               mode_nx = MODE_TOP;
               if (req_ch < CHAR_UPPER_A || req_ch > CHAR_UPPER_Z) begin
                  first_error_nx = ERR_BAD_C;
               end
            end
            MODE_X_HEX, MODE_U_HEX, MODE_UB_HEX1, MODE_UB_HEX2: begin
               if (!is_hex_digit(req_ch)) begin
                  first_error_nx = (mode_ff == MODE_X_HEX) ? ERR_BAD_X : ERR_BAD_U;
                  mode_nx        = MODE_TOP;
               end else begin
                  hex_left_nx = hex_dec;
                  if (hex_dec == 2'd0) begin
                     if (mode_ff == MODE_UB_HEX1) begin
                        mode_nx = MODE_UB_SEL;
                     end else if (mode_ff == MODE_UB_HEX2) begin
                        mode_nx = MODE_UB_CLOSE;
                     end else begin
                        mode_nx = MODE_TOP;
                     end
                  end
               end
            end
            MODE_U_FIRST: begin
               if (req_ch == "{") begin
                  mode_nx     = MODE_UB_HEX1;
                  hex_left_nx = 2'd2;
               end else if (is_hex_digit(req_ch)) begin
                  mode_nx     = MODE_U_HEX;
                  hex_left_nx = 2'd3;
               end else begin
                  first_error_nx = ERR_BAD_U;
                  mode_nx        = MODE_TOP;
               end
            end
            MODE_UB_SEL: begin
               if (req_ch == "-") begin
                  mode_nx     = MODE_UB_HEX2;
                  hex_left_nx = 2'd3;
               end else if (is_hex_digit(req_ch)) begin
                  mode_nx     = MODE_UB_HEX2;
                  hex_left_nx = 2'd1;
               end else begin
                  first_error_nx = ERR_BAD_U;
                  mode_nx        = MODE_TOP;
               end
            end
            MODE_UB_CLOSE: begin
               mode_nx = MODE_TOP;
               if (req_ch != "}") begin
                  first_error_nx = ERR_BAD_U;
               end
            end
            MODE_PQL: begin
               mode_nx = (req_ch == "=" || req_ch == "!") ? MODE_LOOK_X : MODE_NAME;
            end
            MODE_LOOK_X: begin
               mode_nx = MODE_LOOK_CLOSE;
            end
            MODE_LOOK_CLOSE: begin
               mode_nx = MODE_TOP;
               if (req_ch != ")") begin
                  first_error_nx = ERR_BAD_LOOK;
               end
            end
            MODE_NAME: begin
               if (req_ch == ">") begin
                  mode_nx = MODE_NAME_ONE;
               end
            end
            MODE_NAME_ONE: begin
               mode_nx = MODE_NAME_CLOSE;
            end
            MODE_NAME_CLOSE: begin
               if (req_ch == ")") begin
                  mode_nx = MODE_TOP;
               end
            end
            MODE_SQUARE: begin
               if (req_ch == "]") begin
                  mode_nx = MODE_TOP;
               end
            end
            MODE_BRACE: begin
               if (req_ch == "}") begin
                  mode_nx = MODE_TOP;
               end else if (req_ch == ",") begin
                  if (seen_comma_ff) begin
                     first_error_nx = ERR_EXTRA_COMMA;
                     mode_nx        = MODE_TOP;
                  end else begin
                     seen_comma_nx = 1'b1;
                  end
               end else if (!is_digit(req_ch)) begin
                  first_error_nx = ERR_BRACE_CHAR;
                  mode_nx        = MODE_TOP;
               end
            end
            default: begin
               mode_nx = MODE_TOP;
            end
         endcase
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      hex_left_in    = hex_left_ff;
      seen_comma_in  = seen_comma_ff;
      first_error_in = first_error_ff;
      redundant_in   = redundant_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ok_in          = ok_ff;
      code_in        = code_ff;
      red_out_in     = red_out_ff;
      if (accept) begin
         if (req_last) begin
            code_in        = (first_error_nx != ERR_NONE) ? first_error_nx : end_code(mode_nx);
            ok_in          = (code_in == ERR_NONE);
            red_out_in     = redundant_nx;
            rsp_valid_in   = 1'b1;
            mode_in        = MODE_TOP;
            hex_left_in    = 2'd0;
            seen_comma_in  = 1'b0;
            first_error_in = ERR_NONE;
            redundant_in   = 1'b0;
         end else begin
            mode_in        = mode_nx;
            hex_left_in    = hex_left_nx;
            seen_comma_in  = seen_comma_nx;
            first_error_in = first_error_nx;
            redundant_in   = redundant_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_TOP;
         hex_left_ff    <= 2'd0;
         seen_comma_ff  <= 1'b0;
         first_error_ff <= ERR_NONE;
         redundant_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         hex_left_ff    <= hex_left_in;
         seen_comma_ff  <= seen_comma_in;
         first_error_ff <= first_error_in;
         redundant_ff   <= redundant_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff      <= ok_in;
      code_ff    <= code_in;
      red_out_ff <= red_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pattern_ok       = ok_ff;
   assign rsp_error_code       = code_ff;
   assign rsp_redundant_escape = red_out_ff;

endmodule
